// ----- hw/rtl/rmc_pkg.sv -----
// rmc_pkg: shared types and constants for the running mean and covariance block
// no dependencies; imported by running_mean_covariance and its checker
`default_nettype none

package rmc_pkg;

  localparam int DIM      = 4;
  localparam int IDX_W    = $clog2(DIM);
  localparam int NENT     = DIM * DIM;
  localparam int ENT_W    = $clog2(NENT);
  localparam int NRES     = DIM + NENT;
  localparam int RIDX_W   = $clog2(NRES);
  localparam int COUNT_W  = 16;
  localparam logic [COUNT_W-1:0] FULL_COUNT = 16'hFFFF;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    ACT_ADD   = 3'd0,
    ACT_REM   = 3'd1,
    ACT_ADDV  = 3'd2,
    ACT_REMV  = 3'd3,
    ACT_CLEAR = 3'd4,
    ACT_READ  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_MEAN   = 2'd1,
    KIND_COV    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_CLEARED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_SCALE,
    OP_TERM,
    OP_VAR,
    OP_MEAN
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SQ,
    ST_OPSET,
    ST_EMUL,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_INIT,
    ST_DIV,
    ST_ACC,
    ST_STAT,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/running_mean_covariance.sv -----
// running_mean_covariance: sample count, mean vector and covariance matrix of 4-element
// points, updated by one shared multiplier and a bit-serial divider; depends on rmc_pkg
//
// usage
//   slave channel: s_tuser = action, s_tdata = x0..x3 then v0..v3 (16 bits each)
//   master channel: m_tuser = kind, m_tlast = last, m_tdata = row, col, value,
//   sample_count, status
//   an add or remove walks 16 covariance entries (scale, weighted outer product,
//   optional variance term) and 4 mean entries; every term is a 64x16 multiply in
//   two passes of the 32x32 multiplier and a rounded restoring divide
//   add/remove: every entry in turn, variance terms only for ADDV/REMV, then one status item
//   clear, refused add, removal that clears, unknown action: straight to the status item
//   read: 20 items, one per cycle while the receiver takes them
//   s_tready is high only in idle; one item is worked on at a time
//   a stalled receiver holds the output register and the sequencer waits on it
//   reset clears count, mean and covariance at once and drops m_tvalid
`default_nettype none

module running_mean_covariance (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // x0, x1, x2, x3, v0, v1, v2, v3
  input  wire logic [rmc_pkg::IN_DATA_W-1:0]     s_tdata,
  // action
  input  wire logic [2:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // row, col, value, sample_count, status, zero pad
  output logic [rmc_pkg::OUT_DATA_W-1:0]         m_tdata,
  // kind
  output logic [1:0]                             m_tuser,
  output logic                                   m_tlast
);
  import rmc_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;

  logic               adding, with_var;
  logic [15:0]        x_reg [DIM];
  logic [15:0]        v_reg [DIM];
  logic [IDX_W-1:0]   k;
  logic [ENT_W-1:0]   ent, ent_next;
  logic [RIDX_W-1:0]  ridx;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] sdiv;
  logic [31:0]        sq;
  logic [24:0]        e_mag [DIM];
  logic [DIM-1:0]     e_neg;
  logic [32:0]        d_mag [DIM];
  logic [DIM-1:0]     d_neg;
  logic [24:0]        ei_mag;
  logic               ei_neg;
  logic [63:0]        mag;
  logic               neg;
  logic [COUNT_W-1:0] mulv;
  logic [31:0]        divv;
  logic [63:0]        prod;
  logic [63:0]        dvd;
  logic [32:0]        rem;
  logic [5:0]         dcnt;
  logic signed [66:0] acc;
  logic [1:0]         stat;
  logic signed [31:0] mean [DIM];
  logic signed [47:0] cov [NENT];

  logic               out_free, accept, entry_done, ent_last, mean_last, diag;
  logic [IDX_W-1:0]   row, col, e_addr, mean_addr;
  logic [ENT_W-1:0]   cov_addr, ridx_cov;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [32:0]        div_t;
  logic               div_ge;
  logic signed [31:0] mean_rd;
  logic signed [47:0] cov_rd;
  logic [24:0]        e_rd_mag;
  logic               e_rd_neg;
  logic signed [33:0] d_full;
  logic [33:0]        d_abs;
  logic [33:0]        d_rnd;
  logic [48:0]        cov_abs;
  logic               neg_eff;
  logic signed [66:0] qs, acc_sum, mean_sum;
  logic signed [47:0] cov_sat;
  logic signed [31:0] mean_sat;
  logic               ridx_is_mean, ridx_last;
  logic [1:0]         out_kind;
  logic [IDX_W-1:0]   out_row, out_col;
  logic signed [47:0] out_value;
  logic               do_clear;

  assign row = ent[2*IDX_W-1:IDX_W];
  assign col = ent[IDX_W-1:0];
  assign diag = (row == col);
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ent_last = (ent == ENT_W'(NENT - 1));
  assign mean_last = (ent == ENT_W'(DIM - 1));
  assign ridx_is_mean = (ridx < RIDX_W'(DIM));
  assign ridx_last = (ridx == RIDX_W'(NRES - 1));
  assign ridx_cov = ENT_W'(ridx - RIDX_W'(DIM));

  // single read address per store
  assign mean_addr = (state == ST_PREP) ? k :
                     (state == ST_READ) ? ridx[IDX_W-1:0] : col;
  assign cov_addr  = (state == ST_READ) ? ridx_cov : ent;
  assign e_addr    = (state == ST_EMUL) ? col : row;
  assign mean_rd   = mean[mean_addr];
  assign cov_rd    = cov[cov_addr];
  assign e_rd_mag  = e_mag[e_addr];
  assign e_rd_neg  = e_neg[e_addr];

  // shared multiplier
  always_comb begin
    unique case (state)
      ST_SQ: begin
        mul_a = {16'b0, sdiv};
        mul_b = {16'b0, sdiv};
      end
      ST_EMUL: begin
        mul_a = {7'b0, ei_mag};
        mul_b = {7'b0, e_rd_mag};
      end
      ST_MUL_HI: begin
        mul_a = mag[63:32];
        mul_b = {16'b0, mulv};
      end
      default: begin
        mul_a = mag[31:0];
        mul_b = {16'b0, mulv};
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider step
  assign div_t  = {rem[31:0], dvd[63]};
  assign div_ge = (div_t >= {1'b0, divv});

  // deviation from the mean and its rounded q.8 form
  assign d_full = $signed({{2{x_reg[k][15]}}, x_reg[k], 16'b0} -
                          {{2{mean_rd[31]}}, mean_rd});
  assign d_abs  = d_full[33] ? 34'(-d_full) : 34'(d_full);
  assign d_rnd  = d_abs + 34'd128;
  assign cov_abs = cov_rd[47] ? 49'(-{cov_rd[47], cov_rd}) : 49'({cov_rd[47], cov_rd});

  // accumulate and saturate
  always_comb begin
    if (op == OP_SCALE) begin
      neg_eff = neg;
    end else if (op == OP_MEAN) begin
      neg_eff = neg ^ !adding;
    end else begin
      neg_eff = neg ^ !adding;
    end
  end
  assign qs = neg_eff ? -$signed({3'b0, dvd}) : $signed({3'b0, dvd});
  assign acc_sum  = ((op == OP_SCALE) ? 67'sd0 : acc) + qs;
  assign mean_sum = {{35{mean_rd[31]}}, mean_rd} + qs;

  always_comb begin
    if (acc_sum[66:47] == {20{acc_sum[66]}}) begin
      cov_sat = acc_sum[47:0];
    end else if (acc_sum[66]) begin
      cov_sat = {1'b1, 47'b0};
    end else begin
      cov_sat = {1'b0, {47{1'b1}}};
    end
    if (mean_sum[66:31] == {36{mean_sum[66]}}) begin
      mean_sat = mean_sum[31:0];
    end else if (mean_sum[66]) begin
      mean_sat = {1'b1, 31'b0};
    end else begin
      mean_sat = {1'b0, {31{1'b1}}};
    end
  end

  // sequencing of the terms
  always_comb begin
    entry_done = 1'b0;
    op_next = op;
    ent_next = ent;
    unique case (op)
      OP_SCALE: op_next = OP_TERM;
      OP_TERM: begin
        if (with_var && diag) begin
          op_next = OP_VAR;
        end else begin
          entry_done = 1'b1;
        end
      end
      OP_VAR: entry_done = 1'b1;
      OP_MEAN: ent_next = ent + ENT_W'(1);
    endcase
    if (entry_done) begin
      if (ent_last) begin
        op_next = OP_MEAN;
        ent_next = '0;
      end else begin
        op_next = OP_SCALE;
        ent_next = ent + ENT_W'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (s_tuser)
            ACT_ADD, ACT_ADDV: state_next = (count >= FULL_COUNT) ? ST_STAT : ST_PREP;
            ACT_REM, ACT_REMV: state_next = (count <= 16'd1) ? ST_STAT : ST_PREP;
            ACT_READ:          state_next = ST_READ;
            default:           state_next = ST_STAT;
          endcase
        end
      end
      ST_PREP:     state_next = (k == IDX_W'(DIM - 1)) ? ST_SQ : ST_PREP;
      ST_SQ:       state_next = ST_OPSET;
      ST_OPSET:    state_next = (op == OP_TERM) ? ST_EMUL : ST_MUL_LO;
      ST_EMUL:     state_next = ST_MUL_LO;
      ST_MUL_LO:   state_next = ST_MUL_HI;
      ST_MUL_HI:   state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      state_next = (dcnt == 6'd63) ? ST_ACC : ST_DIV;
      ST_ACC:      state_next = (op == OP_MEAN && mean_last) ? ST_STAT : ST_OPSET;
      ST_STAT:     state_next = out_free ? ST_IDLE : ST_STAT;
      ST_READ:     state_next = (out_free && ridx_last) ? ST_IDLE : ST_READ;
      default:     state_next = ST_IDLE;
    endcase
  end

  // handshake and output selection
  always_comb begin
    s_tready = (state == ST_IDLE);
    do_clear = 1'b0;
    if (accept) begin
      priority case (s_tuser)
        ACT_REM, ACT_REMV: do_clear = (count <= 16'd1);
        ACT_CLEAR:         do_clear = 1'b1;
        default:           do_clear = 1'b0;
      endcase
    end
    if (state == ST_READ) begin
      out_kind  = ridx_is_mean ? KIND_MEAN : KIND_COV;
      out_row   = ridx_is_mean ? ridx[IDX_W-1:0] : ridx_cov[2*IDX_W-1:IDX_W];
      out_col   = ridx_is_mean ? '0 : ridx_cov[IDX_W-1:0];
      out_value = ridx_is_mean ? 48'({{16{mean_rd[31]}}, mean_rd}) : cov_rd;
    end else begin
      out_kind  = KIND_STATUS;
      out_row   = '0;
      out_col   = '0;
      out_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      for (int i = 0; i < DIM; i++) begin
        mean[i] <= '0;
      end
      for (int i = 0; i < NENT; i++) begin
        cov[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (do_clear) begin
        count <= '0;
        for (int i = 0; i < DIM; i++) begin
          mean[i] <= '0;
        end
        for (int i = 0; i < NENT; i++) begin
          cov[i] <= '0;
        end
      end
      if (state == ST_ACC) begin
        if (op == OP_MEAN) begin
          mean[col] <= mean_sat;
          if (mean_last) begin
            count <= adding ? count + 16'd1 : count - 16'd1;
          end
        end else if (entry_done) begin
          cov[ent] <= cov_sat;
        end
      end
      if ((state == ST_STAT || state == ST_READ) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < DIM; i++) begin
            x_reg[i] <= s_tdata[16*i +: 16];
            v_reg[i] <= s_tdata[16*(DIM+i) +: 16];
          end
          adding   <= (s_tuser == ACT_ADD) || (s_tuser == ACT_ADDV);
          with_var <= (s_tuser == ACT_ADDV) || (s_tuser == ACT_REMV);
          sdiv     <= ((s_tuser == ACT_ADD) || (s_tuser == ACT_ADDV)) ?
                      count + 16'd1 : count - 16'd1;
          k        <= '0;
          ent      <= '0;
          op       <= OP_SCALE;
          ridx     <= '0;
          priority case (s_tuser)
            ACT_ADD, ACT_ADDV: stat <= (count >= FULL_COUNT) ? STAT_FULL : STAT_OK;
            ACT_REM, ACT_REMV: stat <= (count <= 16'd1) ? STAT_CLEARED : STAT_OK;
            default:           stat <= STAT_OK;
          endcase
        end
      end
      ST_PREP: begin
        d_mag[k] <= d_abs[32:0];
        d_neg[k] <= d_full[33];
        e_mag[k] <= d_rnd[32:8];
        e_neg[k] <= d_full[33];
        k <= k + IDX_W'(1);
      end
      ST_SQ: sq <= mul_p[31:0];
      ST_OPSET: begin
        unique case (op)
          OP_SCALE: begin
            mag  <= 64'(cov_abs);
            neg  <= cov_rd[47];
            mulv <= count;
            divv <= {16'b0, sdiv};
          end
          OP_TERM: begin
            ei_mag <= e_rd_mag;
            ei_neg <= e_rd_neg;
            mulv   <= count;
            divv   <= sq;
          end
          OP_VAR: begin
            mag  <= {16'b0, v_reg[row], 32'b0} >> 16;
            neg  <= 1'b0;
            mulv <= 16'd1;
            divv <= {16'b0, sdiv};
          end
          OP_MEAN: begin
            mag  <= {31'b0, d_mag[col]};
            neg  <= d_neg[col];
            mulv <= 16'd1;
            divv <= {16'b0, sdiv};
          end
        endcase
      end
      ST_EMUL: begin
        mag <= mul_p;
        neg <= ei_neg ^ e_rd_neg;
      end
      ST_MUL_LO: prod <= mul_p;
      ST_MUL_HI: prod <= prod + {mul_p[31:0], 32'b0};
      ST_DIV_INIT: begin
        dvd  <= prod + {33'b0, divv[31:1]};
        rem  <= '0;
        dcnt <= '0;
      end
      ST_DIV: begin
        rem  <= div_ge ? div_t - {1'b0, divv} : div_t;
        dvd  <= {dvd[62:0], div_ge};
        dcnt <= dcnt + 6'd1;
      end
      ST_ACC: begin
        acc <= acc_sum;
        op  <= op_next;
        ent <= ent_next;
      end
      ST_STAT: begin
        if (out_free) begin
          m_tdata <= {2'b0, stat, count, out_value, out_col, out_row};
          m_tuser <= out_kind;
          m_tlast <= 1'b1;
        end
      end
      ST_READ: begin
        if (out_free) begin
          m_tdata <= {2'b0, STAT_OK, count, out_value, out_col, out_row};
          m_tuser <= out_kind;
          m_tlast <= ridx_last;
          ridx    <= ridx + RIDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rmc_checker.sv -----
// rmc_checker: port-level assertions for running_mean_covariance
// depends on rmc_pkg; attached to the top level by the bind below
`default_nettype none

module rmc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic [rmc_pkg::IN_DATA_W-1:0]     s_tdata,
  input wire logic [2:0]                        s_tuser,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [rmc_pkg::OUT_DATA_W-1:0]    m_tdata,
  input wire logic [1:0]                        m_tuser,
  input wire logic                              m_tlast
);
  import rmc_pkg::*;

  // busy after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after accept");

  // status items always close their run
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast)
    else $error("status item without last");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind running_mean_covariance rmc_checker u_rmc_checker (.*);

`default_nettype wire
